// ===== rtl/smpq_pkg.sv =====
// Shared types and codes for the sorted min-priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

   typedef struct packed {
      logic                       action;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  top_value;
      logic                       is_empty;
      logic                       is_full;
      logic [STATUS_W-1:0]        status;
   } rsp_type;

   // Broadcast to every cell for one queue operation.
   typedef struct packed {
      logic                       push;
      logic                       pop;
      logic signed [VALUE_W-1:0]  value;
   } cell_ctrl_type;

endpackage

// ===== rtl/sorted_min_priority_queue.sv =====
// Top level of the sorted min-priority queue: cell row, occupancy and result register.
`timescale 1ns / 1ps

// Sorted min-priority queue. Values live in a row of CAPACITY cells kept in
// ascending signed order; every cell decides its own move from its neighbors in
// the same cycle, so one item is taken per cycle while req_ready is high. The
// result (smallest value, flags, status) is registered and shown
// the cycle after acceptance; a new item is taken while that result waits if
// rsp_ready is high. Push into a full queue and pop from an empty one leave the
// contents unchanged and report a status code. No clearing pass after reset.
module sorted_min_priority_queue #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  smpq_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output smpq_pkg::rsp_type  rsp_payload
);
   import smpq_pkg::*;

   localparam int unsigned OCC_W = $clog2(CAPACITY + 1);

   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             accept;
   logic             full, empty;
   cell_ctrl_type    ctrl;

   logic                      lt_v        [CAPACITY];
   logic signed [VALUE_W-1:0] data_v      [CAPACITY];
   logic signed [VALUE_W-1:0] data_next_v [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (occ_ff == OCC_W'(CAPACITY));
   assign empty     = (occ_ff == '0);

   assign ctrl.push  = accept && (req_payload.action == ACTION_PUSH) && !full;
   assign ctrl.pop   = accept && (req_payload.action == ACTION_POP) && !empty;
   assign ctrl.value = req_payload.value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      prev_lt;
      logic signed [VALUE_W-1:0] prev_data;
      logic signed [VALUE_W-1:0] next_data;

      if (i == 0) begin : g_head
         assign prev_lt   = 1'b0;
         assign prev_data = '0;
      end else begin : g_body
         assign prev_lt   = lt_v[i-1];
         assign prev_data = data_v[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_data = '0;
      end else begin : g_link
         assign next_data = data_v[i+1];
      end

      smpq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .valid     (occ_ff > OCC_W'(i)),
         .prev_lt   (prev_lt),
         .prev_data (prev_data),
         .next_data (next_data),
         .lt        (lt_v[i]),
         .data      (data_v[i]),
         .data_next (data_next_v[i])
      );
   end

   always_comb begin
      occ_in = occ_ff;
      if (ctrl.push) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (ctrl.pop) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_comb begin
      rsp_in.top_value = (occ_in != '0) ? data_next_v[0] : '0;
      rsp_in.is_empty  = (occ_in == '0);
      rsp_in.is_full   = (occ_in == OCC_W'(CAPACITY));
      rsp_in.status    = STATUS_OK;
      if (req_payload.action == ACTION_PUSH && full) begin
         rsp_in.status = STATUS_PUSH_FULL;
      end else if (req_payload.action == ACTION_POP && empty) begin
         rsp_in.status = STATUS_POP_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the result until taken; load a new one only on acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/smpq_cell.sv =====
// One cell of the sorted array: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps

module smpq_cell (
   input  logic                                   clock,
   input  smpq_pkg::cell_ctrl_type                ctrl,
   input  logic                                   valid,
   input  logic                                   prev_lt,
   input  logic signed [smpq_pkg::VALUE_W-1:0]    prev_data,
   input  logic signed [smpq_pkg::VALUE_W-1:0]    next_data,
   output logic                                   lt,
   output logic signed [smpq_pkg::VALUE_W-1:0]    data,
   output logic signed [smpq_pkg::VALUE_W-1:0]    data_next
);
   import smpq_pkg::*;

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;

   // New value belongs at or before this cell: empty slot or strictly smaller.
   assign lt = !valid || (ctrl.value < data_ff);

   always_comb begin
      data_in = data_ff;
      if (ctrl.push) begin
         if (prev_lt) begin
            data_in = prev_data;
         end else if (lt) begin
            data_in = ctrl.value;
         end
      end else if (ctrl.pop) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign data_next = data_in;

endmodule
